/* src/pbr_pkg.sv */
`default_nettype none
package pbr_pkg;

	typedef enum logic [2:0] {
		KIND_LOAD_OFFSET = 3'd0,
		KIND_LOAD_B1     = 3'd1,
		KIND_RF_SAMPLE   = 3'd2,
		KIND_READ_MZ     = 3'd3,
		KIND_RESET_MAG   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		CFG_DT_TURN_SCALE    = 2'd0,
		CFG_FREQ_POINTS_USED = 2'd1,
		CFG_B1_POINTS_USED   = 2'd2
	} cfg_index_t;

	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	// arctan(2^-i) in Q0.32 turns, truncated
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051D;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2E;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9;
			5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F;
			5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B;
			5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000028;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000002;
			5'd29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] clamp_q30(input logic signed [66:0] v);
		logic signed [31:0] r;
		if (v > 67'sd1073741824)
			r = ONE_Q30;
		else if (v < -67'sd1073741824)
			r = -ONE_Q30;
		else
			r = v[31:0];
		return r;
	endfunction

	// (v + 2^29) >> 30 with floor, then saturate
	function automatic logic signed [31:0] round_q30(input logic signed [66:0] v);
		logic signed [66:0] t;
		t = (v + 67'sd536870912) >>> 30;
		return clamp_q30(t);
	endfunction

endpackage
`default_nettype wire

/* src/pbr_ram.sv */
`default_nettype none
module pbr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                                 rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* src/pbr_mul.sv */
`default_nettype none
module pbr_mul (
	input  wire logic               clk,
	input  wire logic signed [32:0] a,
	input  wire logic signed [32:0] b,
	output logic signed [65:0]      p
);
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule
`default_nettype wire

/* src/pbr_cordic.sv */
`default_nettype none
module pbr_cordic #(
	parameter int CORDIC_STEPS = 24
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [31:0]  angle,
	output logic              busy,
	output logic              done,
	output logic signed [31:0] cos_val,
	output logic signed [31:0] sin_val
);
	import pbr_pkg::*;

	localparam logic [4:0] STEP_LAST = 5'(CORDIC_STEPS - 1);

	logic              busy_q, done_q, flip_q;
	logic [4:0]        i_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [33:0] x_n, y_n, z_n, dx, dy, at;
	logic [31:0]       fold_chk, a_fold;
	logic              flip_c;

	assign fold_chk = angle + 32'h40000000;
	assign flip_c   = fold_chk[31];
	assign a_fold   = flip_c ? (angle + 32'h80000000) : angle;

	always_comb begin
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = $signed({2'b00, atan_turn(i_q)});
		if (!z_q[33]) begin
			x_n = x_q - dx;
			y_n = y_q + dy;
			z_n = z_q - at;
		end else begin
			x_n = x_q + dx;
			y_n = y_q - dy;
			z_n = z_q + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && i_q == STEP_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			flip_q <= flip_c;
			x_q    <= CORDIC_GAIN_Q30;
			y_q    <= '0;
			z_q    <= {{2{a_fold[31]}}, a_fold};
			i_q    <= '0;
		end else if (busy_q) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
			i_q <= i_q + 5'd1;
			if (i_q == STEP_LAST) begin
				cos_val <= flip_q ? -clamp_q30(67'(x_n)) : clamp_q30(67'(x_n));
				sin_val <= flip_q ? -clamp_q30(67'(y_n)) : clamp_q30(67'(y_n));
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
endmodule
`default_nettype wire

/* src/rf_pulse_bloch_rotator.sv */
`default_nettype none
// Channel   Dir  Signals                          Request
// s_axis    in   s_tvalid s_tready s_tdata s_tuser  one command (kind in tuser)
// m_axis    out  m_tvalid m_tready m_tdata         one mz result (read only)
// cfg       in   cfg_valid cfg_ready cfg_index cfg_data  register write
//
// Loads and unknown kinds finish on acceptance; a read passes through ST_RD_WAIT when in
// range and then ST_RD_PUT, plus output wait. An rf sample needs, per isochromat in use,
// three rotations through the single CORDIC and 18 products through the single multiplier.
// After reset and after a reset item, a clearing pass over all FREQ_POINTS*B1_POINTS
// isochromats rewrites the magnetization memories; no request is taken meanwhile.
// A pending result only stalls a following read; cfg_ready is always high.
module rf_pulse_bloch_rotator #(
	parameter int FREQ_POINTS  = 32,
	parameter int B1_POINTS    = 16,
	parameter int CORDIC_STEPS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [4:0] freq_index, [8:5] b1_index, [28:9] table_value, [44:29] rf_real,
	// [60:45] rf_imag, [63:61] zero
	input  wire logic [63:0] s_tdata,
	// [2:0] kind
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [31:0] mz_value
	output logic [31:0]      m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import pbr_pkg::*;

	localparam int ISO = FREQ_POINTS * B1_POINTS;
	localparam int IW  = (ISO > 1) ? $clog2(ISO) : 1;
	localparam int FW  = (FREQ_POINTS > 1) ? $clog2(FREQ_POINTS) : 1;
	localparam int BW  = (B1_POINTS > 1) ? $clog2(B1_POINTS) : 1;

	typedef enum logic [9:0] {
		ST_CLR     = 10'b0000000001,
		ST_IDLE    = 10'b0000000010,
		ST_RD_WAIT = 10'b0000000100,
		ST_RD_PUT  = 10'b0000001000,
		ST_LOAD    = 10'b0000010000,
		ST_FETCH   = 10'b0000100000,
		ST_ANG     = 10'b0001000000,
		ST_CORD    = 10'b0010000000,
		ST_ROT     = 10'b0100000000,
		ST_WB      = 10'b1000000000
	} state_t;

	typedef enum logic [1:0] {ROT_X, ROT_Y, ROT_Z} rot_t;

	state_t state_q;
	rot_t   rot_q;

	// input fields
	logic [4:0]         fi;
	logic [3:0]         bi;
	logic signed [19:0] tv;
	logic signed [15:0] re_in, im_in;
	logic               accept;
	assign fi     = s_tdata[4:0];
	assign bi     = s_tdata[8:5];
	assign tv     = s_tdata[28:9];
	assign re_in  = s_tdata[44:29];
	assign im_in  = s_tdata[60:45];
	assign accept = s_tvalid && s_tready;

	// config
	logic [31:0] dt_q;
	logic [5:0]  cfg_freq_q;
	logic [4:0]  cfg_b1_q;
	logic [8:0]  nf, nb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q       <= '0;
			cfg_freq_q <= 6'd32;
			cfg_b1_q   <= 5'd16;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DT_TURN_SCALE:    dt_q       <= cfg_data;
				CFG_FREQ_POINTS_USED: cfg_freq_q <= cfg_data[5:0];
				CFG_B1_POINTS_USED:   cfg_b1_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end
	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_freq_q == 6'd0)
			nf = 9'd1;
		else if (9'(cfg_freq_q) > 9'(FREQ_POINTS))
			nf = 9'(FREQ_POINTS);
		else
			nf = 9'(cfg_freq_q);
		if (cfg_b1_q == 5'd0)
			nb = 9'd1;
		else if (9'(cfg_b1_q) > 9'(B1_POINTS))
			nb = 9'(B1_POINTS);
		else
			nb = 9'(cfg_b1_q);
	end

	// address decode for loads and reads
	logic        fi_ok, bi_ok;
	logic [16:0] rd_lin;
	assign fi_ok  = 9'(fi) < 9'(FREQ_POINTS);
	assign bi_ok  = 9'(bi) < 9'(B1_POINTS);
	assign rd_lin = 17'(fi) * 17'(B1_POINTS) + 17'(bi);

	// sequencer registers
	logic [IW-1:0] clr_q;
	logic [IW-1:0] k_q, row_q;
	logic [FW-1:0] f_q;
	logic [BW-1:0] b_q;
	logic [2:0]    op_q;
	logic signed [15:0] re_q, im_q;
	logic signed [19:0] off_q;
	logic [15:0]   b1v_q;
	logic [47:0]   base_q;
	logic signed [65:0] acc_q;
	logic [31:0]   angx_q, angy_q, angz_q;
	logic signed [31:0] mx_q, my_q, mz_q, t_q;
	logic signed [31:0] rd_val_q;
	logic          out_valid_q;
	logic [31:0]   out_q;

	// memories
	logic          mag_we;
	logic [IW-1:0] mag_waddr, mz_raddr;
	logic [31:0]   wx, wy, wz, rx, ry, rz;
	logic [19:0]   off_rdata;
	logic [15:0]   b1_rdata;
	logic          off_we, b1_we;

	assign mag_we    = (state_q == ST_CLR) || (state_q == ST_WB);
	assign mag_waddr = (state_q == ST_CLR) ? clr_q : k_q;
	assign wx        = (state_q == ST_CLR) ? 32'd0 : mx_q;
	assign wy        = (state_q == ST_CLR) ? 32'd0 : my_q;
	assign wz        = (state_q == ST_CLR) ? ONE_Q30 : mz_q;
	assign mz_raddr  = (state_q == ST_IDLE) ? rd_lin[IW-1:0] : k_q;
	assign off_we    = accept && kind_t'(s_tuser) == KIND_LOAD_OFFSET && fi_ok;
	assign b1_we     = accept && kind_t'(s_tuser) == KIND_LOAD_B1 && bi_ok;

	pbr_ram #(.WIDTH(32), .DEPTH(ISO)) u_mag_x (
		.clk(clk), .we(mag_we), .waddr(mag_waddr), .wdata(wx), .raddr(k_q), .rdata(rx)
	);
	pbr_ram #(.WIDTH(32), .DEPTH(ISO)) u_mag_y (
		.clk(clk), .we(mag_we), .waddr(mag_waddr), .wdata(wy), .raddr(k_q), .rdata(ry)
	);
	pbr_ram #(.WIDTH(32), .DEPTH(ISO)) u_mag_z (
		.clk(clk), .we(mag_we), .waddr(mag_waddr), .wdata(wz), .raddr(mz_raddr), .rdata(rz)
	);
	pbr_ram #(.WIDTH(20), .DEPTH(FREQ_POINTS)) u_offset (
		.clk(clk), .we(off_we), .waddr(FW'(fi)), .wdata(tv), .raddr(f_q), .rdata(off_rdata)
	);
	pbr_ram #(.WIDTH(16), .DEPTH(B1_POINTS)) u_b1 (
		.clk(clk), .we(b1_we), .waddr(BW'(bi)), .wdata(tv[15:0]), .raddr(b_q),
		.rdata(b1_rdata)
	);

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	pbr_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

	// shared CORDIC
	logic               cord_start, cord_busy, cord_done;
	logic [31:0]        cord_angle;
	logic signed [31:0] cos_v, sin_v;
	pbr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start), .angle(cord_angle),
		.busy(cord_busy), .done(cord_done), .cos_val(cos_v), .sin_val(sin_v)
	);

	assign cord_start = (state_q == ST_ANG && op_q == 3'd6) ||
		(state_q == ST_ROT && op_q == 3'd4 && rot_q != ROT_Z);
	assign cord_angle = (state_q == ST_ANG) ? angx_q : ((rot_q == ROT_X) ? angy_q : angz_q);

	// rotation operands: new A = A*c + B*s1, new B = A*s2 + B*c
	logic signed [31:0] rot_a, rot_b;
	logic signed [32:0] s1, s2;
	always_comb begin
		rot_a = (rot_q == ROT_X) ? my_q : mx_q;
		rot_b = (rot_q == ROT_Z) ? my_q : mz_q;
		s1    = (rot_q == ROT_Y) ? 33'(sin_v) : -33'(sin_v);
		s2    = -s1;
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_ANG) begin
			unique case (op_q)
				3'd0: begin mul_a = $signed({1'b0, dt_q});          mul_b = $signed({17'd0, b1v_q}); end
				3'd1: begin mul_a = $signed({9'd0, prod[23:0]});    mul_b = 33'(re_q); end
				3'd2: begin mul_a = $signed({9'd0, base_q[47:24]}); mul_b = 33'(re_q); end
				3'd3: begin mul_a = $signed({9'd0, base_q[23:0]});  mul_b = 33'(im_q); end
				3'd4: begin mul_a = $signed({9'd0, base_q[47:24]}); mul_b = 33'(im_q); end
				3'd5: begin mul_a = $signed({1'b0, dt_q});          mul_b = 33'(off_q); end
				default: ;
			endcase
		end else if (state_q == ST_ROT) begin
			unique case (op_q)
				3'd0: begin mul_a = 33'(rot_a); mul_b = 33'(cos_v); end
				3'd1: begin mul_a = 33'(rot_b); mul_b = s1; end
				3'd2: begin mul_a = 33'(rot_a); mul_b = s2; end
				3'd3: begin mul_a = 33'(rot_b); mul_b = 33'(cos_v); end
				default: ;
			endcase
		end
	end

	// bits 14..45 of lo + hi*2^24
	logic [45:0]        ang_sum;
	logic signed [31:0] rnd_v;
	logic               last_b, last_f;
	assign ang_sum = acc_q[45:0] + {prod[21:0], 24'd0};
	assign rnd_v   = round_q30(67'(acc_q) + 67'(prod));
	assign last_b  = 9'(b_q) == nb - 9'd1;
	assign last_f  = 9'(f_q) == nf - 9'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			op_q        <= '0;
		end else begin
			if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(ISO - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (s_tuser)
							KIND_RF_SAMPLE: state_q <= ST_LOAD;
							KIND_READ_MZ:   state_q <= (fi_ok && bi_ok) ? ST_RD_WAIT : ST_RD_PUT;
							KIND_RESET_MAG: begin
								clr_q   <= '0;
								state_q <= ST_CLR;
							end
							default: ;
						endcase
					end
				end
				ST_RD_WAIT: state_q <= ST_RD_PUT;
				ST_RD_PUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_LOAD:  state_q <= ST_FETCH;
				ST_FETCH: begin
					op_q    <= '0;
					state_q <= ST_ANG;
				end
				ST_ANG: begin
					op_q <= op_q + 3'd1;
					if (op_q == 3'd6)
						state_q <= ST_CORD;
				end
				ST_CORD: begin
					if (cord_done) begin
						op_q    <= '0;
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					op_q <= op_q + 3'd1;
					if (op_q == 3'd4)
						state_q <= (rot_q == ROT_Z) ? ST_WB : ST_CORD;
				end
				ST_WB: begin
					if (last_b && last_f)
						state_q <= ST_IDLE;
					else
						state_q <= ST_LOAD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				re_q     <= re_in;
				im_q     <= im_in;
				f_q      <= '0;
				b_q      <= '0;
				k_q      <= '0;
				row_q    <= '0;
				rd_val_q <= '0;
			end
			ST_RD_WAIT: rd_val_q <= rz;
			ST_RD_PUT: begin
				// hold the presented result until it is taken
				if (!out_valid_q)
					out_q <= rd_val_q;
			end
			ST_FETCH: begin
				mx_q  <= rx;
				my_q  <= ry;
				mz_q  <= rz;
				off_q <= off_rdata;
				b1v_q <= b1_rdata;
			end
			ST_ANG: begin
				unique case (op_q)
					3'd1: base_q <= prod[47:0];
					3'd2: acc_q  <= prod;
					3'd3: angx_q <= ang_sum[45:14];
					3'd4: acc_q  <= prod;
					3'd5: angy_q <= ang_sum[45:14];
					3'd6: begin
						angz_q <= prod[31:0];
						rot_q  <= ROT_X;
					end
					default: ;
				endcase
			end
			ST_ROT: begin
				unique case (op_q)
					3'd1: acc_q <= prod;
					3'd2: t_q   <= rnd_v;
					3'd3: acc_q <= prod;
					3'd4: begin
						unique case (rot_q)
							ROT_X: begin my_q <= t_q; mz_q <= rnd_v; rot_q <= ROT_Y; end
							ROT_Y: begin mx_q <= t_q; mz_q <= rnd_v; rot_q <= ROT_Z; end
							default: begin mx_q <= t_q; my_q <= rnd_v; end
						endcase
					end
					default: ;
				endcase
			end
			ST_WB: begin
				if (last_b) begin
					f_q   <= f_q + 1'b1;
					b_q   <= '0;
					row_q <= IW'(row_q + B1_POINTS);
					k_q   <= IW'(row_q + B1_POINTS);
				end else begin
					b_q <= b_q + 1'b1;
					k_q <= k_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	assert property (@(posedge clk) disable iff (!arst_n) cord_start |-> !cord_busy)
		else $error("cordic restarted while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		mag_we |-> (state_q != ST_IDLE && !s_tready))
		else $error("magnetization written while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_PUT && !out_valid_q) |=> m_tvalid)
		else $error("read result not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> state_q == ST_CORD)
		else $error("cordic finished outside wait");
endmodule
`default_nettype wire

/* sim/rf_pulse_bloch_rotator_tb.sv */
`default_nettype none
module rf_pulse_bloch_rotator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pbr_pkg::*;

	localparam int NF = 32;
	localparam int NB = 16;
	localparam int STEPS = 24;
	localparam longint UNIT = 64'sd1073741824;
	localparam longint GAIN = 64'sd652032874;
	localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] KIND_UNUSED_LAST = 3'd7;

	localparam logic [31:0] ATAN_Q32 [0:STEPS-1] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	rf_pulse_bloch_rotator uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow state of the isochromat grid
	longint             iso_x [NF*NB];
	longint             iso_y [NF*NB];
	longint             iso_z [NF*NB];
	logic signed [19:0] offset_hz [NF];
	logic [15:0]        b1_scale [NB];
	logic [31:0]        dt_scale;
	logic [5:0]         freq_used;
	logic [4:0]         b1_used;

	logic [31:0] mz_pending [$];
	int          mismatches;
	int          failures;
	int          reads_checked;
	int          rf_samples;
	int          cfg_writes;
	bit          steady;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint sat_q30(input longint v);
		if (v > UNIT) return UNIT;
		if (v < -UNIT) return -UNIT;
		return v;
	endfunction

	function automatic longint mix(input longint p, input longint cp,
			input longint q, input longint cq);
		return sat_q30((p * cp + q * cq + (UNIT >>> 1)) >>> 30);
	endfunction

	task automatic sincos(input logic [31:0] ang, output longint c, output longint s);
		longint     x, y, z, dx, dy;
		logic [31:0] a;
		bit          flip;
		a = ang + 32'h40000000;
		flip = a[31];
		a = flip ? ang + 32'h80000000 : ang;
		x = GAIN;
		y = 0;
		z = longint'($signed(a));
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_Q32[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_Q32[i]);
			end
		end
		x = sat_q30(x);
		y = sat_q30(y);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic equilibrium();
		for (int i = 0; i < NF*NB; i++) begin
			iso_x[i] = 0; iso_y[i] = 0; iso_z[i] = UNIT;
		end
	endtask

	task automatic rotate_grid(input logic signed [15:0] re, input logic signed [15:0] im);
		int          nf, nb, k;
		logic [63:0] pz, base, px, py;
		longint      cz, sz, c, s, mx, my, mz, t;
		nf = (freq_used == 0) ? 1 : (freq_used > NF) ? NF : freq_used;
		nb = (b1_used == 0) ? 1 : (b1_used > NB) ? NB : b1_used;
		for (int f = 0; f < nf; f++) begin
			pz = {32'b0, dt_scale} * {{44{offset_hz[f][19]}}, offset_hz[f]};
			sincos(pz[31:0], cz, sz);
			for (int b = 0; b < nb; b++) begin
				k = f * NB + b;
				base = {32'b0, dt_scale} * {48'b0, b1_scale[b]};
				px = base * {{48{re[15]}}, re};
				py = base * {{48{im[15]}}, im};
				mx = iso_x[k]; my = iso_y[k]; mz = iso_z[k];
				sincos(px[45:14], c, s);
				t = mix(my, c, mz, -s);
				mz = mix(my, s, mz, c);
				my = t;
				sincos(py[45:14], c, s);
				t = mix(mx, c, mz, s);
				mz = mix(mx, -s, mz, c);
				mx = t;
				t = mix(mx, cz, my, -sz);
				my = mix(mx, sz, my, cz);
				mx = t;
				iso_x[k] = mx; iso_y[k] = my; iso_z[k] = mz;
			end
		end
	endtask

	task automatic predict_request(input logic [2:0] kind, input logic [63:0] d);
		logic [4:0]  fi;
		logic [3:0]  bi;
		fi = d[4:0];
		bi = d[8:5];
		case (kind)
			KIND_LOAD_OFFSET: offset_hz[fi] = d[28:9];
			KIND_LOAD_B1:     b1_scale[bi] = d[24:9];
			KIND_RF_SAMPLE: begin
				rotate_grid(d[44:29], d[60:45]);
				rf_samples++;
			end
			KIND_READ_MZ:     mz_pending.push_back(iso_z[fi * NB + bi][31:0]);
			KIND_RESET_MAG:   equilibrium();
			default: ;
		endcase
	endtask

	task automatic send_request(input logic [2:0] kind, input logic [4:0] fi,
			input logic [3:0] bi, input logic [19:0] tv, input logic [15:0] re,
			input logic [15:0] im);
		int          gap;
		logic [63:0] d;
		d = {3'b0, im, re, tv, bi, fi};
		gap = steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_request(kind, d);
	endtask

	// read one isochromat, then wait for the block to drain before any register write
	task automatic drain();
		send_request(KIND_READ_MZ, $urandom, $urandom, $urandom, $urandom, $urandom);
		s_tvalid <= 1'b0;
		while (mz_pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_DT_TURN_SCALE:    dt_scale = value;
			CFG_FREQ_POINTS_USED: freq_used = value[5:0];
			CFG_B1_POINTS_USED:   b1_used = value[4:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic setup(input logic [31:0] dt, input logic [5:0] nf, input logic [4:0] nb);
		drain();
		write_reg(CFG_DT_TURN_SCALE, dt);
		write_reg(CFG_FREQ_POINTS_USED, {$urandom_range(0, 3) == 0 ? 26'($urandom) : 26'd0, nf});
		write_reg(CFG_B1_POINTS_USED, {27'd0, nb});
	endtask

	task automatic rf(input logic [15:0] re, input logic [15:0] im);
		send_request(KIND_RF_SAMPLE, $urandom, $urandom, $urandom, re, im);
	endtask

	task automatic read_mz(input logic [4:0] fi, input logic [3:0] bi);
		send_request(KIND_READ_MZ, fi, bi, $urandom, $urandom, $urandom);
	endtask

	// every table entry gets written before any rf sample uses it
	task automatic test_table_fill();
		for (int f = 0; f < NF; f++)
			send_request(KIND_LOAD_OFFSET, f, $urandom,
				(f == 0) ? 20'h80000 : (f == 1) ? 20'h7FFFF : 20'($urandom),
				$urandom, $urandom);
		for (int b = 0; b < NB; b++)
			send_request(KIND_LOAD_B1, $urandom, b,
				(b == 0) ? 20'hF0000 : (b == 1) ? 20'h0FFFF : 20'($urandom),
				$urandom, $urandom);
	endtask

	task automatic test_directed();
		read_mz(5'd0, 4'd0);
		read_mz(5'd31, 4'd15);
		setup(32'h0001_0000, 6'd2, 5'd2);
		rf(16'h8000, 16'h0000);
		rf(16'h7FFF, 16'h7FFF);
		rf(16'h0000, 16'h8000);
		read_mz(5'd0, 4'd0);
		read_mz(5'd1, 4'd1);
		read_mz(5'd2, 4'd0);
		for (logic [2:0] k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST && k != 3'd0; k++)
			send_request(k, $urandom, $urandom, $urandom, $urandom, $urandom);
		read_mz(5'd1, 4'd0);
		send_request(KIND_RESET_MAG, $urandom, $urandom, $urandom, $urandom, $urandom);
		read_mz(5'd0, 4'd0);
		read_mz(5'd1, 4'd1);
	endtask

	// counts below one and above the grid, dt at both extremes
	task automatic test_count_extremes();
		setup(32'hFFFF_FFFF, 6'd0, 5'd0);
		rf($urandom, $urandom);
		read_mz(5'd0, 4'd0);
		read_mz(5'd0, 4'd1);
		setup(32'h0000_4000, 6'd63, 5'd31);
		rf($urandom, $urandom);
		read_mz(5'd31, 4'd15);
		read_mz(5'd17, 4'd9);
		setup(32'h0000_0000, 6'd32, 5'd16);
		rf($urandom, $urandom);
		read_mz(5'd3, 4'd3);
	endtask

	task automatic test_random(input int phases, input int per_phase);
		int          pick;
		logic [2:0]  kind;
		for (int p = 0; p < phases; p++) begin
			setup((p % 4 == 0) ? 32'($urandom_range(0, 65535)) : $urandom,
				$urandom_range(1, 4), $urandom_range(1, 4));
			steady = (p % 3 == 2);
			for (int n = 0; n < per_phase; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 10) kind = KIND_LOAD_OFFSET;
				else if (pick < 18) kind = KIND_LOAD_B1;
				else if (pick < 50) kind = KIND_RF_SAMPLE;
				else if (pick < 90) kind = KIND_READ_MZ;
				else if (pick < 95) kind = KIND_RESET_MAG;
				else kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
				// reads mostly land inside the active corner of the grid
				if (kind == KIND_READ_MZ && $urandom_range(0, 3) != 0)
					read_mz($urandom_range(0, 4), $urandom_range(0, 4));
				else
					send_request(kind, $urandom, $urandom, $urandom, $urandom, $urandom);
			end
			steady = 1'b0;
		end
	endtask

	// result sink with random stalls
	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = steady ? 0 : $urandom_range(0, 10);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!(m_tvalid && m_tready)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (mz_pending.size() == 0) begin
				failures++;
				if (mismatches < 10) $display("unexpected result mz=%0d", $signed(m_tdata));
				mismatches++;
			end else begin
				logic [31:0] want;
				want = mz_pending.pop_front();
				reads_checked++;
				if (m_tdata !== want) begin
					failures++;
					if (mismatches < 10)
						$display("mz mismatch: expected %0d got %0d",
							$signed(want), $signed(m_tdata));
					mismatches++;
				end
			end
		end
	end

	initial begin
		#100_000_000;
		$display("timeout");
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;
		mismatches = 0;
		failures = 0;
		reads_checked = 0;
		rf_samples = 0;
		cfg_writes = 0;
		dt_scale = '0;
		freq_used = 6'd32;
		b1_used = 5'd16;
		equilibrium();
		for (int i = 0; i < NF; i++) offset_hz[i] = '0;
		for (int i = 0; i < NB; i++) b1_scale[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_fill();
		test_directed();
		test_count_extremes();
		test_random(8, 85);

		s_tvalid <= 1'b0;
		while (mz_pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mz_pending.size() != 0) failures++;

		$display("covered %0d rf samples, %0d register writes; %0d mz reads compared",
			rf_samples, cfg_writes, reads_checked);
		$display("mismatches: %0d", mismatches);
		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
